// ===== rtl/bdasc_pkg.sv =====
package bdasc_pkg;

    localparam int NUM_DIGITS = 16;
    localparam int DIGIT_W    = 4;
    localparam int FIELD_W    = 64;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_CMP = 2'd2;

    localparam logic [1:0] ORD_LT = 2'b11;
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;

    localparam logic [4:0] DIGIT_MAX = 5'd9;
    localparam logic [4:0] DIGIT_TEN = 5'd10;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef t_digit [NUM_DIGITS-1:0] t_digits;

endpackage

// ===== rtl/bcd_decimal_add_sub_compare_top.sv =====
// An input transfer reaches o_out_valid through four register stages, s1 to s4.
// Throughput: one item per cycle; the four pipeline stages advance together and
// hold while the output register is full and not taken.
// Reset: synchronous active-low i_rst_n clears every stage valid bit; payload
// registers are not reset.
module bcd_decimal_add_sub_compare_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_a_digits,
    input  logic        i_a_negative,
    input  logic [63:0] i_b_digits,
    input  logic        i_b_negative,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_result_digits,
    output logic        o_result_negative,
    output logic        o_overflow,
    output logic signed [1:0] o_order,
    output logic        o_bad_digit
);

    localparam int DW = bdasc_pkg::DIGIT_W;
    localparam int ND = bdasc_pkg::NUM_DIGITS;
    localparam int FIELD_BITS = ND * DW;

    logic w_adv;

    // stage valid bits
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;

    // stage 1: operands, digit checks, compare
    bdasc_pkg::t_digits r_s1_a, r_s1_b;
    logic       r_s1_arith, r_s1_sub, r_s1_neg, r_s1_bad;
    logic [1:0] r_s1_ord;
    bdasc_pkg::t_digits n_s1_a, n_s1_b;
    logic       n_s1_arith, n_s1_sub, n_s1_bad;
    logic [1:0] n_s1_ord;

    // stage 2: per-digit results for both carry-ins plus generate/propagate
    bdasc_pkg::t_digits r_s2_r0, r_s2_r1;
    logic [ND-1:0] r_s2_g, r_s2_p;
    logic       r_s2_arith, r_s2_sub, r_s2_neg, r_s2_bad;
    logic [1:0] r_s2_ord;
    bdasc_pkg::t_digits n_s2_r0, n_s2_r1;
    logic [ND-1:0] n_s2_g, n_s2_p;

    // stage 3: carry-resolved digits, complement flag, overflow and sign
    bdasc_pkg::t_digits r_s3_res;
    logic       r_s3_tc, r_s3_neg, r_s3_ovf, r_s3_bad;
    logic [1:0] r_s3_ord;
    bdasc_pkg::t_digits n_s3_res;
    logic       n_s3_tc, n_s3_neg, n_s3_ovf;

    // stage 4: output register
    bdasc_pkg::t_digits r_s4_res;
    logic       r_s4_neg, r_s4_ovf, r_s4_bad;
    logic [1:0] r_s4_ord;
    bdasc_pkg::t_digits n_s4_res;

    assign w_adv      = !r_s4_valid || i_out_ready;
    assign o_in_ready = w_adv;

    always_comb begin
        logic a_bad, b_bad, a_zero, b_zero, eff_b_neg;
        logic [FIELD_BITS-1:0] a_flat, b_flat;
        a_bad = 1'b0;
        b_bad = 1'b0;
        for (int i = 0; i < ND; i++) begin
            n_s1_a[i] = i_a_digits[i*DW +: DW];
            n_s1_b[i] = i_b_digits[i*DW +: DW];
            a_bad     = a_bad | (n_s1_a[i] > 4'd9);
            b_bad     = b_bad | (n_s1_b[i] > 4'd9);
        end
        a_flat    = n_s1_a;
        b_flat    = n_s1_b;
        a_zero    = (a_flat == '0);
        b_zero    = (b_flat == '0);
        n_s1_bad  = a_bad | b_bad;
        n_s1_arith = !n_s1_bad &&
                     (i_cmd == bdasc_pkg::CMD_ADD || i_cmd == bdasc_pkg::CMD_SUB);
        eff_b_neg = (i_cmd == bdasc_pkg::CMD_SUB) ? !i_b_negative : i_b_negative;
        n_s1_sub  = (i_a_negative != eff_b_neg);

        n_s1_ord = bdasc_pkg::ORD_EQ;
        if (!n_s1_bad && i_cmd == bdasc_pkg::CMD_CMP) begin
            if (a_zero && b_zero) begin
                n_s1_ord = bdasc_pkg::ORD_EQ;
            end else if (a_zero) begin
                n_s1_ord = i_b_negative ? bdasc_pkg::ORD_GT : bdasc_pkg::ORD_LT;
            end else if (b_zero) begin
                n_s1_ord = i_a_negative ? bdasc_pkg::ORD_LT : bdasc_pkg::ORD_GT;
            end else if (i_a_negative != i_b_negative) begin
                n_s1_ord = i_a_negative ? bdasc_pkg::ORD_LT : bdasc_pkg::ORD_GT;
            end else if (a_flat == b_flat) begin
                n_s1_ord = bdasc_pkg::ORD_EQ;
            end else begin
                // valid BCD at equal width orders like a binary integer
                n_s1_ord = ((a_flat > b_flat) != i_a_negative) ?
                           bdasc_pkg::ORD_GT : bdasc_pkg::ORD_LT;
            end
        end
    end

    always_comb begin
        logic [4:0] x, y, sum, dif;
        for (int i = 0; i < ND; i++) begin
            x   = {1'b0, r_s1_a[i]};
            y   = {1'b0, r_s1_b[i]};
            sum = x + y;
            dif = x - y;
            if (r_s1_sub) begin
                n_s2_g[i]  = (x < y);
                n_s2_p[i]  = (x == y);
                n_s2_r0[i] = n_s2_g[i] ? 4'(dif + bdasc_pkg::DIGIT_TEN) : dif[3:0];
                n_s2_r1[i] = (n_s2_g[i] || n_s2_p[i]) ?
                             4'(dif + bdasc_pkg::DIGIT_MAX) : 4'(dif - 5'd1);
            end else begin
                n_s2_g[i]  = (sum > bdasc_pkg::DIGIT_MAX);
                n_s2_p[i]  = (sum == bdasc_pkg::DIGIT_MAX);
                n_s2_r0[i] = n_s2_g[i] ? 4'(sum - bdasc_pkg::DIGIT_TEN) : sum[3:0];
                n_s2_r1[i] = (n_s2_g[i] || n_s2_p[i]) ?
                             4'(sum - bdasc_pkg::DIGIT_MAX) : 4'(sum + 5'd1);
            end
        end
    end

    // ripple the decimal carry or borrow across the digits
    always_comb begin
        logic [ND:0] c;
        c[0] = 1'b0;
        for (int i = 0; i < ND; i++) begin
            c[i+1]      = r_s2_g[i] | (r_s2_p[i] & c[i]);
            n_s3_res[i] = c[i] ? r_s2_r1[i] : r_s2_r0[i];
        end
        if (!r_s2_arith) begin
            n_s3_res = '0;
        end
        n_s3_tc  = r_s2_arith && r_s2_sub && c[ND];
        n_s3_ovf = r_s2_arith && !r_s2_sub && c[ND];
        n_s3_neg = r_s2_arith && (r_s2_neg ^ (r_s2_sub && c[ND]));
    end

    // ten's complement: digits below the lowest nonzero stay zero
    always_comb begin
        logic lower_nz;
        lower_nz = 1'b0;
        for (int i = 0; i < ND; i++) begin
            if (!r_s3_tc) begin
                n_s4_res[i] = r_s3_res[i];
            end else if (lower_nz) begin
                n_s4_res[i] = 4'd9 - r_s3_res[i];
            end else if (r_s3_res[i] == 4'd0) begin
                n_s4_res[i] = 4'd0;
            end else begin
                n_s4_res[i] = 4'd10 - r_s3_res[i];
            end
            lower_nz = lower_nz | (r_s3_res[i] != 4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_a     <= n_s1_a;
            r_s1_b     <= n_s1_b;
            r_s1_arith <= n_s1_arith;
            r_s1_sub   <= n_s1_sub;
            r_s1_neg   <= i_a_negative;
            r_s1_bad   <= n_s1_bad;
            r_s1_ord   <= n_s1_ord;

            r_s2_r0    <= n_s2_r0;
            r_s2_r1    <= n_s2_r1;
            r_s2_g     <= n_s2_g;
            r_s2_p     <= n_s2_p;
            r_s2_arith <= r_s1_arith;
            r_s2_sub   <= r_s1_sub;
            r_s2_neg   <= r_s1_neg;
            r_s2_bad   <= r_s1_bad;
            r_s2_ord   <= r_s1_ord;

            r_s3_res   <= n_s3_res;
            r_s3_tc    <= n_s3_tc;
            r_s3_neg   <= n_s3_neg;
            r_s3_ovf   <= n_s3_ovf;
            r_s3_bad   <= r_s2_bad;
            r_s3_ord   <= r_s2_ord;

            r_s4_res   <= n_s4_res;
            r_s4_neg   <= r_s3_neg;
            r_s4_ovf   <= r_s3_ovf;
            r_s4_bad   <= r_s3_bad;
            r_s4_ord   <= r_s3_ord;
        end
    end

    assign o_out_valid       = r_s4_valid;
    assign o_result_digits   = 64'(r_s4_res);
    assign o_result_negative = r_s4_neg;
    assign o_overflow        = r_s4_ovf;
    assign o_order           = r_s4_ord;
    assign o_bad_digit       = r_s4_bad;

endmodule

// ===== rtl/bdasc_checker.sv =====
module bdasc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] o_result_digits,
    input  logic        o_result_negative,
    input  logic        o_overflow,
    input  logic [1:0]  o_order,
    input  logic        o_bad_digit
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_result_digits) && $stable(o_order) &&
         $stable(o_result_negative)))
        else $error("stalled result changed");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_digit) |->
        (o_result_digits == '0 && !o_result_negative && !o_overflow &&
         o_order == bdasc_pkg::ORD_EQ))
        else $error("bad digit result not cleared");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_order != bdasc_pkg::ORD_EQ) |->
        (o_result_digits == '0 && !o_result_negative && !o_overflow))
        else $error("compare result carries arithmetic fields");

    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_order != 2'b10))
        else $error("order out of range");

    // pipeline keeps moving when the output is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input blocked while output free");

endmodule

bind bcd_decimal_add_sub_compare_top bdasc_checker u_bdasc_checker (.*);
